// ===== rtl/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types, codes and helper functions of the number string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

   localparam int CHAR_W   = 8;
   localparam int VALUE_W  = 64;
   localparam int COUNT_W  = 16;
   localparam int BASE_W   = 5;
   localparam int MODE_W   = 2;
   localparam int DIGIT_W  = 5;
   localparam int ADDR_W   = 3;
   localparam int CSR_W    = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 80;

   // Register index taken from the word address.
   localparam logic REG_BASE = 1'b0;
   localparam logic REG_MODE = 1'b1;

   localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUFFIX   = 2'd2;

   localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
   localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
   localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

   localparam logic [DIGIT_W-1:0] NOT_DIGIT = 5'd16;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
   localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
   localparam logic [CHAR_W-1:0] CH_K_UP  = 8'h4B;
   localparam logic [CHAR_W-1:0] CH_K_LO  = 8'h6B;
   localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
   localparam logic [CHAR_W-1:0] CH_B     = 8'h42;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEAD   = 3'd1,
      PH_ZERO   = 3'd2,
      PH_ZEROX  = 3'd3,
      PH_DIGITS = 3'd4,
      PH_SUFK   = 3'd5,
      PH_SUFI   = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [VALUE_W-1:0]   acc;
      logic [BASE_W-1:0]    abase;
      logic [COUNT_W-1:0]   count;
      logic                 negative;
   } parse_state_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [MODE_W-1:0] mode;
   } cfg_type;

   function automatic logic [DIGIT_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
      logic [DIGIT_W-1:0] v;
      v = NOT_DIGIT;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = DIGIT_W'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = DIGIT_W'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = DIGIT_W'(c - 8'h37);
      end
      return v;
   endfunction

   function automatic logic [COUNT_W-1:0] count_add(input logic [COUNT_W-1:0] c,
                                                    input logic [1:0] n);
      logic [COUNT_W:0] s;
      s = {1'b0, c} + {{(COUNT_W-1){1'b0}}, n};
      return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/nsp_csr.sv =====
// ----------------------------------------------------------------------------
// nsp_csr
// Register file for base and parse mode, written and read over APB.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_csr
   import nsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]  pwdata,
   output logic      [CSR_W-1:0]  prdata,
   output cfg_type                cfg
);

   logic [BASE_W-1:0] base_ff, base_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              wr_en;

   // Only the word address matters; the byte offset is ignored.
   assign wr_en = psel & penable & pwrite;

   always_comb begin
      base_in = base_ff;
      mode_in = mode_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_BASE: base_in = pwdata[BASE_W-1:0];
            REG_MODE: mode_in = pwdata[MODE_W-1:0];
            default:  base_in = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         mode_ff <= MODE_UNSIGNED;
      end else begin
         base_ff <= base_in;
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_BASE: prdata = {{(CSR_W-BASE_W){1'b0}}, base_ff};
         REG_MODE: prdata = {{(CSR_W-MODE_W){1'b0}}, mode_ff};
         default:  prdata = '0;
      endcase
   end

   assign cfg.base = base_ff;
   assign cfg.mode = mode_ff;

endmodule

`default_nettype wire

// ===== rtl/nsp_step.sv =====
// ----------------------------------------------------------------------------
// nsp_step
// Next-state logic of the parser: one character against the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_step
   import nsp_pkg::*;
(
   input  wire parse_state_type     cur,
   input  wire logic [CHAR_W-1:0]   ch,
   input  wire logic                start,
   input  wire cfg_type             cfg,
   output parse_state_type          nxt,
   output logic                     fire,
   output logic [VALUE_W-1:0]       value,
   output logic [COUNT_W-1:0]       consumed
);

   logic [DIGIT_W-1:0] hv;
   phase_type          ph;
   logic [VALUE_W-1:0] acc;
   logic [VALUE_W-1:0] prod;
   logic [BASE_W-1:0]  ab;
   logic [COUNT_W-1:0] cnt;
   logic               neg;
   logic               do_lead;
   logic               do_digit;
   logic               suffix_mode;

   assign hv          = hex_value(ch);
   assign suffix_mode = (cfg.mode == MODE_SUFFIX);

   always_comb begin
      ph       = cur.phase;
      acc      = cur.acc;
      ab       = cur.abase;
      cnt      = cur.count;
      neg      = cur.negative;
      do_lead  = 1'b0;
      do_digit = 1'b0;
      fire     = 1'b0;
      prod     = '0;

      if (start) begin
         acc = '0;
         cnt = '0;
         neg = 1'b0;
         ab  = '0;
         ph  = PH_LEAD;
         if (cfg.mode == MODE_SIGNED && ch == CH_MINUS) begin
            neg = 1'b1;
            cnt = count_add(cnt, 2'd1);
         end else begin
            do_lead = 1'b1;
         end
      end else begin
         case (cur.phase)
            PH_LEAD: do_lead = 1'b1;
            PH_ZERO: begin
               if (ch == CH_X) begin
                  ph = PH_ZEROX;
               end else begin
                  ab       = (cfg.base != '0) ? cfg.base : BASE_OCT;
                  do_digit = 1'b1;
               end
            end
            PH_ZEROX: begin
               if (hv < NOT_DIGIT) begin
                  ab       = BASE_HEX;
                  cnt      = count_add(cnt, 2'd1);
                  do_digit = 1'b1;
               end else begin
                  fire = 1'b1;
               end
            end
            PH_DIGITS: do_digit = 1'b1;
            PH_SUFK: begin
               if (ch == CH_I) begin
                  ph = PH_SUFI;
               end else begin
                  fire = 1'b1;
               end
            end
            PH_SUFI: begin
               cnt  = count_add(cnt, (ch == CH_B) ? 2'd3 : 2'd2);
               fire = 1'b1;
            end
            default: ph = PH_IDLE;
         endcase
      end

      if (do_lead) begin
         if (ch == CH_ZERO) begin
            cnt = count_add(cnt, 2'd1);
            ph  = PH_ZERO;
         end else begin
            ab       = (cfg.base != '0) ? cfg.base : BASE_DEC;
            do_digit = 1'b1;
         end
      end

      // The base is at most five bits wide, so the multiply is a sum of
      // up to five shifted copies of the accumulator.
      for (int i = 0; i < BASE_W; i++) begin
         if (ab[i]) begin
            prod = prod + (acc << i);
         end
      end

      if (do_digit) begin
         if (hv < ab) begin
            acc = prod + {{(VALUE_W-DIGIT_W){1'b0}}, hv};
            cnt = count_add(cnt, 2'd1);
            ph  = PH_DIGITS;
         end else if (suffix_mode && ch == CH_G) begin
            acc = acc << 30;
            ph  = PH_SUFK;
         end else if (suffix_mode && ch == CH_M) begin
            acc = acc << 20;
            ph  = PH_SUFK;
         end else if (suffix_mode && (ch == CH_K_UP || ch == CH_K_LO)) begin
            acc = acc << 10;
            ph  = PH_SUFK;
         end else begin
            fire = 1'b1;
         end
      end

      if (fire) begin
         ph = PH_IDLE;
      end

      nxt.phase    = ph;
      nxt.acc      = acc;
      nxt.abase    = ab;
      nxt.count    = cnt;
      nxt.negative = neg;
   end

   always_comb begin
      if (cfg.mode == MODE_SIGNED && neg) begin
         value = '0 - acc;
      end else if (suffix_mode) begin
         value = {{(VALUE_W-32){acc[31]}}, acc[31:0]};
      end else begin
         value = acc;
      end
   end

   assign consumed = cnt;

endmodule

`default_nettype wire

// ===== rtl/number_string_parser.sv =====
// ----------------------------------------------------------------------------
// number_string_parser
// Character-stream integer parser with base detection and size suffixes.
// ----------------------------------------------------------------------------
// Usage:
//   Characters enter on the req_ stream, one per request; req_tuser marks
//   the first character of a string. At most one result per string leaves on the
//   rsp_ stream when the parse ends: the value in the low 64 bits of
//   rsp_tdata and the count of consumed characters above it.
//   Base and parse mode are set over the csr_ APB port; the user sets them only
//   while no string is in flight, which the block does not enforce; pready is tied high.
//   An accepted request is held in the input register, and the parse step
//   then writes the result register from it, which drives rsp_tvalid. A
//   request can be accepted every cycle while the receiver does not stall;
//   the rate is set by the combinational multiply-add of the accumulator by
//   the base.
//   When the receiver stalls, the result register holds, the input register
//   fills, and req_tready drops until the result is taken.
//   Reset clears the parser to idle, empties both registers and sets base
//   and mode to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module number_string_parser
   import nsp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] ch
   input  wire logic                  req_tuser,   // [0] start_req
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [63:0] value, [79:64] consumed
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ADDR_W-1:0]     csr_paddr,
   input  wire logic [CSR_W-1:0]      csr_pwdata,
   output logic      [CSR_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cfg_type            cfg;
   parse_state_type    state_ff, state_in;
   parse_state_type    step_nxt;
   logic               step_fire;
   logic [VALUE_W-1:0] step_value;
   logic [COUNT_W-1:0] step_consumed;

   logic               in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]  in_ch_ff, in_ch_in;
   logic               in_start_ff, in_start_in;

   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic               advance;
   logic               step_go;

   nsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   nsp_step u_step (
      .cur      (state_ff),
      .ch       (in_ch_ff),
      .start    (in_start_ff),
      .cfg      (cfg),
      .nxt      (step_nxt),
      .fire     (step_fire),
      .value    (step_value),
      .consumed (step_consumed)
   );

   // The step may run whenever the result register is free or being emptied.
   assign advance    = ~out_valid_ff | rsp_tready;
   assign step_go    = in_valid_ff & advance;
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      in_start_in = in_start_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_ch_in    = req_tdata[CHAR_W-1:0];
         in_start_in = req_tuser;
      end

      state_in = step_go ? step_nxt : state_ff;

      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      if (advance) begin
         out_valid_in = step_go & step_fire;
         out_value_in = step_value;
         out_count_in = step_consumed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         state_ff.phase     <= PH_IDLE;
         state_ff.acc       <= '0;
         state_ff.abase     <= '0;
         state_ff.count     <= '0;
         state_ff.negative  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff     <= in_ch_in;
      in_start_ff  <= in_start_in;
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_count_ff, out_value_ff};

endmodule

`default_nettype wire

// ===== verif/number_string_parser_test.sv =====
// ----------------------------------------------------------------------------
// number_string_parser_test
// Self-checking testbench for the character-stream integer parser. Strings
// go in one character per request with random gaps. Each accepted request
// also runs through a local model of the parser, and every result taken from
// the block is compared with the oldest predicted number. The run sweeps the
// base and parse mode registers over several settings, the extremes among
// them, while the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module number_string_parser_test
   import nsp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_REPORTS = 20;

   localparam logic [ADDR_W-1:0] ADDR_BASE = 3'd0;
   localparam logic [ADDR_W-1:0] ADDR_MODE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] consumed;
   } parsed_number_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] ch
   logic                  req_tuser = 1'b0; // [0] start_req
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [63:0] value, [79:64] consumed
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_W-1:0]      csr_pwdata = '0;
   logic [CSR_W-1:0]      csr_prdata;
   logic                  csr_pready;

   // Local copy of the parser state and its registers.
   phase_type          num_phase = PH_IDLE;
   logic [VALUE_W-1:0] num_acc = '0;
   logic [BASE_W-1:0]  num_base = '0;
   logic [COUNT_W-1:0] num_count = '0;
   logic               num_negative = 1'b0;
   logic [BASE_W-1:0]  cfg_base = '0;
   logic [MODE_W-1:0]  cfg_mode = MODE_UNSIGNED;

   parsed_number_type expected_numbers[$];
   int unsigned    mismatches = 0;
   int unsigned    request_count = 0;
   int unsigned    result_count = 0;
   int unsigned    setting_count = 0;
   int unsigned    quiet_cycles = 0;
   int unsigned    burst_left = 0;
   stall_kind_type stall_kind = STALL_NONE;
   int unsigned    stall_left = 0;

   number_string_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
      // Decimal digits, then lower and upper case hex letters.
      if (c inside {[8'h30:8'h39]}) return DIGIT_W'(c - 8'h30);
      if (c inside {[8'h61:8'h66]}) return DIGIT_W'(c - 8'h61 + 8'd10);
      if (c inside {[8'h41:8'h46]}) return DIGIT_W'(c - 8'h41 + 8'd10);
      return NOT_DIGIT;
   endfunction

   function automatic void bump_count(input int unsigned n);
      int unsigned sum;
      sum = num_count + n;
      num_count = (sum > 32'hFFFF) ? '1 : COUNT_W'(sum);
   endfunction

   function automatic bit finish_number(output parsed_number_type r);
      logic [VALUE_W-1:0] v;
      v = num_acc;
      if (cfg_mode == MODE_SIGNED && num_negative) begin
         v = '0 - v;
      end else if (cfg_mode == MODE_SUFFIX) begin
         v = {{32{v[31]}}, v[31:0]};
      end
      r.value = v;
      r.consumed = num_count;
      num_phase = PH_IDLE;
      return 1'b1;
   endfunction

   // Note that the "no digit" code is itself below any base above 16.
   function automatic bit take_digit(input logic [CHAR_W-1:0] c,
                                     output parsed_number_type r);
      logic [DIGIT_W-1:0] d;
      d = digit_value(c);
      r = '0;
      if (d < num_base) begin
         num_acc = num_acc * VALUE_W'(num_base) + VALUE_W'(d);
         bump_count(1);
         num_phase = PH_DIGITS;
         return 1'b0;
      end
      if (cfg_mode == MODE_SUFFIX) begin
         if (c == CH_G) begin
            num_acc = num_acc << 30;
            num_phase = PH_SUFK;
            return 1'b0;
         end
         if (c == CH_M) begin
            num_acc = num_acc << 20;
            num_phase = PH_SUFK;
            return 1'b0;
         end
         if (c == CH_K_UP || c == CH_K_LO) begin
            num_acc = num_acc << 10;
            num_phase = PH_SUFK;
            return 1'b0;
         end
      end
      return finish_number(r);
   endfunction

   function automatic bit take_lead(input logic [CHAR_W-1:0] c,
                                    output parsed_number_type r);
      r = '0;
      if (c == CH_ZERO) begin
         bump_count(1);
         num_phase = PH_ZERO;
         return 1'b0;
      end
      num_base = (cfg_base != '0) ? cfg_base : BASE_DEC;
      return take_digit(c, r);
   endfunction

   function automatic bit step_number_parse(input logic [CHAR_W-1:0] c, input logic opens,
                                            output parsed_number_type r);
      bit produced;
      produced = 1'b0;
      r = '0;
      if (opens) begin
         num_acc = '0;
         num_count = '0;
         num_negative = 1'b0;
         num_base = '0;
         num_phase = PH_LEAD;
         if (cfg_mode == MODE_SIGNED && c == CH_MINUS) begin
            num_negative = 1'b1;
            bump_count(1);
         end else begin
            produced = take_lead(c, r);
         end
      end else begin
         case (num_phase)
            PH_LEAD: begin
               produced = take_lead(c, r);
            end
            PH_ZERO: begin
               if (c == CH_X) begin
                  num_phase = PH_ZEROX;
               end else begin
                  num_base = (cfg_base != '0) ? cfg_base : BASE_OCT;
                  produced = take_digit(c, r);
               end
            end
            PH_ZEROX: begin
               if (digit_value(c) != NOT_DIGIT) begin
                  num_base = BASE_HEX;
                  bump_count(1);
                  produced = take_digit(c, r);
               end else begin
                  produced = finish_number(r);
               end
            end
            PH_DIGITS: begin
               produced = take_digit(c, r);
            end
            PH_SUFK: begin
               if (c == CH_I) begin
                  num_phase = PH_SUFI;
               end else begin
                  produced = finish_number(r);
               end
            end
            PH_SUFI: begin
               bump_count((c == CH_B) ? 3 : 2);
               produced = finish_number(r);
            end
            default: begin
               num_phase = PH_IDLE;
            end
         endcase
      end
      return produced;
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard, receiver and watchdog
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("MISMATCH %s: got %h, expected %h (after request %0d)",
                  what, got, want, request_count);
      end
   endtask

   // Prediction comes first so that a result never races its own request.
   always @(posedge clock) begin : scoreboard
      parsed_number_type predicted;
      parsed_number_type oldest;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            request_count++;
            if (step_number_parse(req_tdata, req_tuser, predicted)) begin
               expected_numbers.push_back(predicted);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_numbers.size() == 0) begin
               report_mismatch("unexpected result value", rsp_tdata[63:0], '0);
            end else begin
               oldest = expected_numbers.pop_front();
               if (rsp_tdata[63:0] !== oldest.value) begin
                  report_mismatch("value", rsp_tdata[63:0], oldest.value);
               end
               if (rsp_tdata[79:64] !== oldest.consumed) begin
                  report_mismatch("consumed", VALUE_W'(rsp_tdata[79:64]),
                                  VALUE_W'(oldest.consumed));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind = stall_kind_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (stall_kind)
         STALL_NONE:  rsp_tready <= 1'b1;
         STALL_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
         STALL_HEAVY: rsp_tready <= ($urandom_range(0, 7) == 0);
         default:     rsp_tready <= (stall_left % 4 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Timeout: no traffic for %0d cycles", QUIET_LIMIT);
      $display("number_string_parser verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic opens);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= opens;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == 0);
      end
   endtask

   // Holds the sender off until every predicted number has arrived.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [ADDR_W-1:0] addr,
                             input logic [CSR_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= write ? data : '0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!write && csr_prdata !== data) begin
         report_mismatch("register read back", VALUE_W'(csr_prdata), VALUE_W'(data));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [BASE_W-1:0] b, input logic [MODE_W-1:0] m);
      settle();
      csr_access(1'b1, ADDR_BASE, CSR_W'(b));
      csr_access(1'b1, ADDR_MODE, CSR_W'(m));
      cfg_base = b;
      cfg_mode = m;
      csr_access(1'b0, ADDR_BASE, CSR_W'(b));
      csr_access(1'b0, ADDR_MODE, CSR_W'(m));
      setting_count++;
   endtask

   function automatic logic [CHAR_W-1:0] digit_char(input int unsigned v);
      if (v < 10) return CH_ZERO + CHAR_W'(v);
      return (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + CHAR_W'(v - 10);
   endfunction

   // A string of random content shaped like a real number, sometimes noise.
   task automatic send_random_string(output int unsigned body);
      logic [CHAR_W-1:0] text[$];
      int unsigned radix;
      int unsigned n;
      int unsigned roll;
      if ($urandom_range(0, 99) < 8) begin
         n = $urandom_range(1, 4);
         repeat (n) send_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         body = n;
         return;
      end
      if (cfg_mode == MODE_SIGNED && $urandom_range(0, 1) == 1) text.push_back(CH_MINUS);
      radix = (cfg_base == '0) ? 10 : ((cfg_base > BASE_HEX) ? 16 : cfg_base);
      case ($urandom_range(0, 5))
         2: begin
            text.push_back(CH_ZERO);
            if (cfg_base == '0) radix = 8;
         end
         3, 4: begin
            text.push_back(CH_ZERO);
            text.push_back(CH_X);
            radix = 16;
         end
         5: begin
            text.push_back(CH_ZERO);
            text.push_back(CH_X_UP);
         end
         default: ;
      endcase
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
      repeat (n) begin
         roll = $urandom_range(0, 9);
         if (roll < 8) text.push_back(digit_char($urandom_range(0, radix - 1)));
         else if (roll == 8) text.push_back(digit_char($urandom_range(0, 15)));
         else text.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      if (cfg_mode == MODE_SUFFIX && $urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 3))
            0: text.push_back(CH_G);
            1: text.push_back(CH_M);
            2: text.push_back(CH_K_UP);
            default: text.push_back(CH_K_LO);
         endcase
         case ($urandom_range(0, 3))
            1: text.push_back(CH_I);
            2: begin
               text.push_back(CH_I);
               text.push_back(CH_B);
            end
            3: begin
               text.push_back(CH_I);
               text.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            default: ;
         endcase
      end
      // Without a terminator the next string's start abandons this one.
      case ($urandom_range(0, 4))
         0: text.push_back(CH_NUL);
         1: text.push_back(CH_SPACE);
         3: ;
         default: text.push_back(CHAR_W'($urandom_range(0, 255)));
      endcase
      if (text.size() == 0) text.push_back(CHAR_W'($urandom_range(0, 255)));
      for (int i = 0; i < text.size(); i++) begin
         send_char(text[i], i == 0);
      end
      body = text.size();
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_base_detection();
      configure('0, MODE_UNSIGNED);
      send_char(CH_NUL, 1'b1);   // empty string
      send_char(8'hFF, 1'b0);    // ignored while idle
      send_char(8'hFF, 1'b1);    // non-ASCII byte is never a digit
      send_text("0xg");          // zero-x without a hex digit
      send_text("0x1f");
      send_char(CH_NUL, 1'b0);
      send_text("017");
      send_char(CH_SPACE, 1'b0);
      send_text("7");            // abandoned by the next start
      send_text("25");
      send_char(CH_NUL, 1'b0);
      configure(BASE_DEC, MODE_UNSIGNED);
      send_text("0xA");          // the prefix forces hex over a set base
      send_char(CH_NUL, 1'b0);
   endtask

   task automatic test_sign_and_suffix();
      configure('0, MODE_SIGNED);
      send_text("-");
      send_char(CH_NUL, 1'b0);
      send_text("-12");
      send_char(CH_NUL, 1'b0);
      configure('0, MODE_SUFFIX);
      send_text("1K ");
      send_text("3GiB");         // wraps into the sign bit of the 32-bit result
      send_text("2Mix");
      // The mode is read per request, the base only once it is resolved.
      configure('0, MODE_UNSIGNED);
      send_text("12");
      configure(BASE_HEX, MODE_SUFFIX);
      send_char(CH_K_UP, 1'b0);
      send_char("b", 1'b0);
   endtask

   task automatic test_random_strings();
      logic [BASE_W-1:0] phase_base[11];
      logic [MODE_W-1:0] phase_mode[11];
      int unsigned quota;
      int unsigned sent;
      int unsigned body;
      phase_base = '{5'd0, 5'd10, 5'd0, 5'd16, 5'd8, 5'd0, 5'd2, 5'd1, 5'd17, 5'd31, 5'd0};
      phase_mode = '{MODE_UNSIGNED, MODE_SIGNED, MODE_SUFFIX, MODE_UNSIGNED, MODE_SUFFIX,
                     MODE_SPARE, MODE_SIGNED, MODE_UNSIGNED, MODE_SUFFIX, MODE_UNSIGNED,
                     MODE_SIGNED};
      for (int p = 0; p < 12; p++) begin
         if (p < 11) begin
            configure(phase_base[p], phase_mode[p]);
         end else begin
            configure(BASE_W'($urandom_range(0, 31)), MODE_W'($urandom_range(0, 3)));
         end
         // Bases above sixteen rarely finish a string.
         quota = (p >= 7 && p <= 9) ? 60 : 140;
         sent = 0;
         while (sent < quota) begin
            send_random_string(body);
            sent += body;
         end
      end
   endtask

   initial begin : main
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_base_detection();
      test_sign_and_suffix();
      test_random_strings();
      settle();
      $display("Run sent %0d requests and checked %0d results over %0d register settings,",
               request_count, result_count, setting_count);
      $display("with base detection, sign, size suffixes and odd bases.");
      if (mismatches == 0) begin
         $display("number_string_parser verification clean");
      end else begin
         $display("number_string_parser verification failed");
      end
      $finish;
   end

endmodule
